>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define BFFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle
`define BFFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/bffc_pkg.sv
package bffc_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;
  localparam int REG_W   = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // walk directions, in the order up, right, down, left
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

  typedef struct packed {
    cmd_e               command;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic               cell_is_o;
  } cmd_t;

  typedef struct packed {
    logic result_is_o;
    logic was_captured;
  } res_t;

endpackage

>>> rtl/bffc_ram.sv
module bffc_ram import bffc_pkg::*; #(
  parameter int Width = 1,
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [2**AddrW];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bffc_fill_ctrl.sv
`include "assert_macros.svh"

module bffc_fill_ctrl import bffc_pkg::*; #(
  parameter int MaxRows = DEF_MAX_ROWS,
  parameter int MaxCols = DEF_MAX_COLS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cmd_t             in_cmd_i,
  input  logic [REG_W-1:0] rows_i,
  input  logic [REG_W-1:0] cols_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int AW   = RowW + ColW;
  localparam int SpW  = AW + 1;
  localparam logic [SpW-1:0] StackDepth = SpW'(2**AW);

  typedef struct packed {
    logic orig;
    logic live;
    logic reached;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_RD_RESP  = 9'b000000010,
    S_SEED     = 9'b000000100,
    S_CHK      = 9'b000001000,
    S_POP      = 9'b000010000,
    S_POP_WAIT = 9'b000100000,
    S_NB       = 9'b001000000,
    S_SWEEP_RD = 9'b010000000,
    S_SWEEP_WR = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [RowW-1:0]   seed_r_q, seed_r_d, cand_r_q, cand_r_d, cur_r_q, cur_r_d;
  logic [ColW-1:0]   seed_c_q, seed_c_d, cand_c_q, cand_c_d, cur_c_q, cur_c_d;
  logic [RowW-1:0]   last_r_q, last_r_d;
  logic [ColW-1:0]   last_c_q, last_c_d;
  logic              seed_done_q, seed_done_d;
  logic              from_seed_q, from_seed_d;
  logic              rd_out_q, rd_out_d;
  dir_e              dir_q, dir_d;
  logic [SpW-1:0]    sp_q, sp_d;

  logic              g_we, g_re;
  logic [AW-1:0]     g_waddr, g_raddr;
  entry_t            g_wdata, g_rdata;
  logic              s_we, s_re;
  logic [AW-1:0]     s_waddr, s_raddr, s_rdata;

  logic [8:0]        rows_eff, cols_eff;
  logic              in_inside;
  logic [RowW-1:0]   in_r, nb_r;
  logic [ColW-1:0]   in_c, nb_c;
  logic              nb_ok, cand_open, push;

  bffc_ram #(.Width($bits(entry_t)), .AddrW(AW)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  bffc_ram #(.Width(AW), .AddrW(AW)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i ({cand_r_q, cand_c_q}),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign rows_eff = ({2'b00, rows_i} > 9'(MaxRows)) ? 9'(MaxRows) : {2'b00, rows_i};
  assign cols_eff = ({2'b00, cols_i} > 9'(MaxCols)) ? 9'(MaxCols) : {2'b00, cols_i};

  assign in_inside = (int'(in_cmd_i.row_index) < MaxRows) &&
                     (int'(in_cmd_i.col_index) < MaxCols);
  assign in_r = RowW'(in_cmd_i.row_index);
  assign in_c = ColW'(in_cmd_i.col_index);

  assign cand_open = !g_rdata.reached && g_rdata.live;
  assign push      = (state_q == S_CHK) && cand_open;

  always_comb begin
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    nb_ok = 1'b0;
    unique case (dir_q)
      DIR_UP: begin
        nb_ok = (cur_r_q != '0);
        nb_r  = cur_r_q - RowW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (cur_c_q != last_c_q);
        nb_c  = cur_c_q + ColW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (cur_r_q != last_r_q);
        nb_r  = cur_r_q + RowW'(1);
      end
      DIR_LEFT: begin
        nb_ok = (cur_c_q != '0);
        nb_c  = cur_c_q - ColW'(1);
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    seed_r_d    = seed_r_q;
    seed_c_d    = seed_c_q;
    seed_done_d = seed_done_q;
    cand_r_d    = cand_r_q;
    cand_c_d    = cand_c_q;
    cur_r_d     = cur_r_q;
    cur_c_d     = cur_c_q;
    last_r_d    = last_r_q;
    last_c_d    = last_c_q;
    from_seed_d = from_seed_q;
    rd_out_d    = rd_out_q;
    dir_d       = dir_q;
    sp_d        = sp_q;

    g_we    = 1'b0;
    g_waddr = {cand_r_q, cand_c_q};
    g_wdata = g_rdata;
    g_re    = 1'b0;
    g_raddr = {cand_r_q, cand_c_q};
    s_we    = 1'b0;
    s_waddr = sp_q[AW-1:0];
    s_re    = 1'b0;
    s_raddr = AW'(sp_q - SpW'(1));

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o.result_is_o  = rd_out_q ? 1'b0 : g_rdata.live;
    res_o.was_captured = rd_out_q ? 1'b0 : (g_rdata.orig && !g_rdata.live);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_cmd_i.command)
            CMD_WRITE: begin
              // a fresh write also leaves the cell unreached for the next run
              g_we    = in_inside;
              g_waddr = {in_r, in_c};
              g_wdata = '{orig: in_cmd_i.cell_is_o, live: in_cmd_i.cell_is_o,
                          reached: 1'b0};
            end
            CMD_RUN: begin
              last_r_d    = RowW'(rows_eff - 9'd1);
              last_c_d    = ColW'(cols_eff - 9'd1);
              seed_r_d    = '0;
              seed_c_d    = '0;
              seed_done_d = 1'b0;
              if ((rows_eff != '0) && (cols_eff != '0)) begin
                state_d = S_SEED;
              end
            end
            CMD_READ: begin
              g_re     = in_inside;
              g_raddr  = {in_r, in_c};
              rd_out_d = !in_inside;
              state_d  = S_RD_RESP;
            end
            CMD_NONE: begin
            end
          endcase
        end
      end
      S_RD_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_SEED: begin
        g_re        = 1'b1;
        g_raddr     = {seed_r_q, seed_c_q};
        cand_r_d    = seed_r_q;
        cand_c_d    = seed_c_q;
        from_seed_d = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        if (cand_open) begin
          g_we    = 1'b1;
          g_wdata = '{orig: g_rdata.orig, live: g_rdata.live, reached: 1'b1};
          s_we    = 1'b1;
          sp_d    = sp_q + SpW'(1);
        end
        if (from_seed_q) begin
          // border rows take every column, other rows only the first and last
          if (seed_c_q == last_c_q) begin
            seed_c_d = '0;
            if (seed_r_q == last_r_q) begin
              seed_done_d = 1'b1;
            end else begin
              seed_r_d = seed_r_q + RowW'(1);
            end
          end else if ((seed_r_q == '0) || (seed_r_q == last_r_q)) begin
            seed_c_d = seed_c_q + ColW'(1);
          end else begin
            seed_c_d = last_c_q;
          end
          state_d = S_POP;
        end else if (dir_q == DIR_LEFT) begin
          state_d = S_POP;
        end else begin
          dir_d   = dir_e'(dir_q + 2'd1);
          state_d = S_NB;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          if (seed_done_q) begin
            cand_r_d = '0;
            cand_c_d = '0;
            state_d  = S_SWEEP_RD;
          end else begin
            state_d = S_SEED;
          end
        end else begin
          s_re    = 1'b1;
          sp_d    = sp_q - SpW'(1);
          state_d = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cur_r_d = s_rdata[AW-1:ColW];
        cur_c_d = s_rdata[ColW-1:0];
        dir_d   = DIR_UP;
        state_d = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          g_re        = 1'b1;
          g_raddr     = {nb_r, nb_c};
          cand_r_d    = nb_r;
          cand_c_d    = nb_c;
          from_seed_d = 1'b0;
          state_d     = S_CHK;
        end else if (dir_q == DIR_LEFT) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
        end
      end
      S_SWEEP_RD: begin
        g_re    = 1'b1;
        state_d = S_SWEEP_WR;
      end
      S_SWEEP_WR: begin
        // capture unreached cells and drop the reached mark
        g_we    = 1'b1;
        g_wdata = '{orig: g_rdata.orig, live: g_rdata.live && g_rdata.reached,
                    reached: 1'b0};
        if (cand_c_q == last_c_q) begin
          cand_c_d = '0;
          if (cand_r_q == last_r_q) begin
            state_d = S_IDLE;
          end else begin
            cand_r_d = cand_r_q + RowW'(1);
            state_d  = S_SWEEP_RD;
          end
        end else begin
          cand_c_d = cand_c_q + ColW'(1);
          state_d  = S_SWEEP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      seed_done_q <= 1'b0;
      dir_q       <= DIR_UP;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      seed_done_q <= seed_done_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_r_q    <= seed_r_d;
    seed_c_q    <= seed_c_d;
    cand_r_q    <= cand_r_d;
    cand_c_q    <= cand_c_d;
    cur_r_q     <= cur_r_d;
    cur_c_q     <= cur_c_d;
    last_r_q    <= last_r_d;
    last_c_q    <= last_c_d;
    from_seed_q <= from_seed_d;
    rd_out_q    <= rd_out_d;
  end

  `BFFC_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push, sp_q != StackDepth, "stack overflow")
  `BFFC_ASSERT_IMP(a_idle_drained, clk_i, rst_ni, state_q == S_IDLE, sp_q == '0, "stack not drained")
  `BFFC_ASSERT_IMP(a_cand_active, clk_i, rst_ni, state_q == S_CHK, (cand_r_q <= last_r_q) && (cand_c_q <= last_c_q), "candidate outside grid")
  `BFFC_ASSERT(a_pop_then_nb, clk_i, rst_ni, (state_q != S_POP_WAIT) || (state_d == S_NB), "pop not followed by walk")

endmodule

>>> rtl/boundary_flood_fill_capture.sv
// Channel   Direction  Transaction carries
// s_axis    in         one command: write cell, run fill or read cell
// m_axis    out        one result per read command
// cfg       in         grid_rows / grid_cols register write, no handshake
//
// Write: the grid memory is written as the command is accepted. Read: the read
// is registered, then the result is offered. Run: border cells and neighbours of
// popped cells are read and checked, then a capture sweep rewrites each active
// cell; one grid memory port pair is the limit. No clearing pass after reset.
// Commands are taken only while no run or read is in progress; a waiting
// result is held in the output register while writes and runs carry on.
module boundary_flood_fill_capture import bffc_pkg::*; #(
  parameter int MaxRows = DEF_MAX_ROWS,
  parameter int MaxCols = DEF_MAX_COLS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [1:0] command, [7:2] row_index, [13:8] col_index, [14] cell_is_o
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] result_is_o, [1] was_captured
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [REG_W-1:0]       cfg_wdata_i
);

  logic [REG_W-1:0] grid_rows_q, grid_cols_q;
  cmd_t             cmd;
  logic             res_valid, res_ready;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  assign cmd.command   = cmd_e'(s_axis_tdata_i[1:0]);
  assign cmd.row_index = s_axis_tdata_i[7:2];
  assign cmd.col_index = s_axis_tdata_i[13:8];
  assign cmd.cell_is_o = s_axis_tdata_i[14];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= REG_W'(64);
      grid_cols_q <= REG_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_wdata_i;
        REG_GRID_COLS: grid_cols_q <= cfg_wdata_i;
      endcase
    end
  end

  bffc_fill_ctrl #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (cmd),
    .rows_i      (grid_rows_q),
    .cols_i      (grid_cols_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees up in the same cycle it is drained
  assign res_ready   = !out_valid_q || m_axis_tready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_q.was_captured, out_q.result_is_o};

endmodule

>>> tb/boundary_flood_fill_capture_tb.sv
module boundary_flood_fill_capture_tb;
  import bffc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT     = 23;
  localparam int HOLD_AT_ITEM = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // [1:0] command, [7:2] row_index, [13:8] col_index, [14] cell_is_o
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // [0] result_is_o, [1] was_captured
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_idx_i = REG_GRID_ROWS;
  logic [REG_W-1:0]       cfg_wdata_i = '0;

  boundary_flood_fill_capture u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------
  bit   grid_now      [DEF_MAX_ROWS][DEF_MAX_COLS];
  bit   grid_written  [DEF_MAX_ROWS][DEF_MAX_COLS];
  bit   border_linked [DEF_MAX_ROWS][DEF_MAX_COLS];
  int   trail_q[$];
  int   pred_rows = DEF_MAX_ROWS;
  int   pred_cols = DEF_MAX_COLS;
  res_t read_results_q[$];

  function automatic void claim_cell(int r, int c, int rows, int cols);
    if (r < 0 || r >= rows || c < 0 || c >= cols) return;
    if (border_linked[r][c] || !grid_now[r][c]) return;
    border_linked[r][c] = 1'b1;
    trail_q.push_back(r * DEF_MAX_COLS + c);
  endfunction

  function automatic void spread_from(int r, int c, int rows, int cols);
    int idx;
    int cr;
    int cc;
    claim_cell(r, c, rows, cols);
    while (trail_q.size() != 0) begin
      idx = trail_q.pop_back();
      cr  = idx / DEF_MAX_COLS;
      cc  = idx % DEF_MAX_COLS;
      claim_cell(cr - 1, cc, rows, cols);
      claim_cell(cr, cc + 1, rows, cols);
      claim_cell(cr + 1, cc, rows, cols);
      claim_cell(cr, cc - 1, rows, cols);
    end
  endfunction

  function automatic void capture_enclosed();
    int rows;
    int cols;
    rows = (pred_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : pred_rows;
    cols = (pred_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : pred_cols;
    for (int r = 0; r < DEF_MAX_ROWS; r++)
      for (int c = 0; c < DEF_MAX_COLS; c++) border_linked[r][c] = 1'b0;
    trail_q.delete();
    if (rows == 0 || cols == 0) return;
    for (int c = 0; c < cols; c++) begin
      spread_from(0, c, rows, cols);
      spread_from(rows - 1, c, rows, cols);
    end
    for (int r = 0; r < rows; r++) begin
      spread_from(r, cols - 1, rows, cols);
      spread_from(r, 0, rows, cols);
    end
    // anything still 'O' and not reached from the border is enclosed
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!border_linked[r][c] && grid_now[r][c]) grid_now[r][c] = 1'b0;
  endfunction

  function automatic void track_command(logic [IN_TDATA_W-1:0] d);
    cmd_e op;
    int   r;
    int   c;
    res_t res;
    op = cmd_e'(d[1:0]);
    r  = d[7:2];
    c  = d[13:8];
    case (op)
      CMD_WRITE: begin
        grid_now[r][c]     = d[14];
        grid_written[r][c] = d[14];
      end
      CMD_RUN: capture_enclosed();
      CMD_READ: begin
        res.result_is_o  = grid_now[r][c];
        res.was_captured = grid_written[r][c] && !grid_now[r][c];
        read_results_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_cmd(cmd_t item);
    return {1'b0, item.cell_is_o, item.col_index, item.row_index, item.command};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and hold-off
  // ---------------------------------------------------------------------------
  cmd_t cmd_q[$];
  int   n_accepted = 0;
  int   n_mismatch = 0;
  int   n_cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic calm;

  assign calm = (n_accepted >= CALM_FIRST) && (n_accepted < CALM_LAST);

  always @(posedge clk_i) begin : drive_commands
    cmd_t item;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        track_command(s_axis_tdata_i);
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          item = cmd_q.pop_front();
          s_axis_tdata_i  <= pack_cmd(item);
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Hold the result side off once so reads back up and stall the command side
  always @(posedge clk_i) begin
    if (!hold_done && n_accepted >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    logic got_o;
    logic got_cap;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_o   = m_axis_tdata_o[0];
        got_cap = m_axis_tdata_o[1];
        if (read_results_q.size() == 0) begin
          $display("%0t: result with none expected, actual tdata %0h", $time, m_axis_tdata_o);
          n_mismatch++;
        end else begin
          want = read_results_q.pop_front();
          if (got_o !== want.result_is_o) begin
            $display("%0t: result_is_o expected %0b actual %0b",
                     $time, want.result_is_o, got_o);
            n_mismatch++;
          end
          if (got_cap !== want.was_captured) begin
            $display("%0t: was_captured expected %0b actual %0b",
                     $time, want.was_captured, got_cap);
            n_mismatch++;
          end
        end
      end
      m_axis_tready_i <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("FAIL boundary_flood_fill_capture");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bit cell_loaded [DEF_MAX_ROWS][DEF_MAX_COLS];
  int loaded_list[$];
  int gen_rows = DEF_MAX_ROWS;
  int gen_cols = DEF_MAX_COLS;
  int n_queued = 0;

  task automatic queue_write(int r, int c, bit v);
    cmd_t item;
    item.command   = CMD_WRITE;
    item.row_index = COORD_W'(r);
    item.col_index = COORD_W'(c);
    item.cell_is_o = v;
    cmd_q.push_back(item);
    n_queued++;
    if (!cell_loaded[r][c]) begin
      cell_loaded[r][c] = 1'b1;
      loaded_list.push_back(r * DEF_MAX_COLS + c);
    end
  endtask

  // reads only ever target cells already loaded
  task automatic queue_read(int r, int c);
    cmd_t item;
    item.command   = CMD_READ;
    item.row_index = COORD_W'(r);
    item.col_index = COORD_W'(c);
    item.cell_is_o = 1'($urandom_range(1));
    cmd_q.push_back(item);
    n_queued++;
  endtask

  task automatic queue_read_any();
    int idx;
    if (gen_rows != 0 && gen_cols != 0 && $urandom_range(2) != 0) begin
      queue_read($urandom_range(gen_rows - 1), $urandom_range(gen_cols - 1));
    end else begin
      idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
      queue_read(idx / DEF_MAX_COLS, idx % DEF_MAX_COLS);
    end
  endtask

  task automatic fill_active();
    for (int r = 0; r < gen_rows; r++)
      for (int c = 0; c < gen_cols; c++)
        if (!cell_loaded[r][c]) queue_write(r, c, 1'($urandom_range(99) < 60));
  endtask

  task automatic queue_run();
    cmd_t item;
    fill_active();
    item.command   = CMD_RUN;
    item.row_index = COORD_W'($urandom_range(63));
    item.col_index = COORD_W'($urandom_range(63));
    item.cell_is_o = 1'($urandom_range(1));
    cmd_q.push_back(item);
    n_queued++;
  endtask

  task automatic queue_unused();
    cmd_t item;
    item.command   = CMD_NONE;
    item.row_index = COORD_W'($urandom_range(63));
    item.col_index = COORD_W'($urandom_range(63));
    item.cell_is_o = 1'($urandom_range(1));
    cmd_q.push_back(item);
  endtask

  // X ring with an 'O' interior: a region that a run must capture unless
  // the interior touches another path to the border
  task automatic queue_ring();
    int h;
    int w;
    int r0;
    int c0;
    if (gen_rows < 3 || gen_cols < 3) return;
    h  = $urandom_range((gen_rows < 5) ? gen_rows : 5, 3);
    w  = $urandom_range((gen_cols < 5) ? gen_cols : 5, 3);
    r0 = $urandom_range(gen_rows - h);
    c0 = $urandom_range(gen_cols - w);
    for (int r = r0; r < r0 + h; r++)
      for (int c = c0; c < c0 + w; c++)
        queue_write(r, c, !(r == r0 || r == r0 + h - 1 || c == c0 || c == c0 + w - 1));
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || s_axis_tvalid_i || read_results_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_grid(int rows_v, int cols_v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_GRID_ROWS;
    cfg_wdata_i <= REG_W'(rows_v);
    @(posedge clk_i);
    cfg_idx_i   <= REG_GRID_COLS;
    cfg_wdata_i <= REG_W'(cols_v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_rows = rows_v;
    pred_cols = cols_v;
    gen_rows  = (rows_v > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_v;
    gen_cols  = (cols_v > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_v;
    @(negedge clk_i);
  endtask

  task automatic random_phase(int n);
    int pick;
    fill_active();
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 46 && gen_rows != 0 && gen_cols != 0) begin
        queue_write($urandom_range(gen_rows - 1), $urandom_range(gen_cols - 1),
                    1'($urandom_range(99) < 60));
      end else if (pick < 56) begin
        queue_write($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      end else if (pick < 84) begin
        queue_read_any();
      end else if (pick < 87) begin
        queue_ring();
      end else if (pick < 95) begin
        queue_run();
        repeat ($urandom_range(6, 2)) queue_read_any();
      end else begin
        queue_unused();
      end
    end
    queue_run();
    queue_read_any();
  endtask

  initial begin
    int rows_v;
    int cols_v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // enclosed centre, border 'O', cell outside the active grid, repeated run
    set_grid(3, 3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        queue_write(r, c, (r == 1 && c == 1) || (r == 0 && c == 2));
    queue_write(63, 63, 1'b1);
    queue_read(1, 1);
    queue_run();
    queue_read(1, 1);
    queue_read(0, 2);
    queue_read(0, 0);
    queue_read(63, 63);
    queue_unused();
    queue_run();
    queue_read(1, 1);

    set_grid(1, 1);
    queue_write(0, 0, 1'b1);
    queue_run();
    queue_read(0, 0);

    // zero rows: the run must leave every cell alone
    set_grid(0, 5);
    queue_run();
    queue_read(1, 1);

    // single-dimension extremes, oversized values saturate
    set_grid(64, 1);
    random_phase(30);
    set_grid(1, 64);
    random_phase(30);
    set_grid(127, 2);
    random_phase(30);
    set_grid(2, 100);
    random_phase(30);

    while (n_queued < ITEM_TARGET) begin
      rows_v = $urandom_range(12, 1);
      cols_v = $urandom_range(12, 1);
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) != 0) rows_v = 0;
        else cols_v = 0;
      end
      set_grid(rows_v, cols_v);
      random_phase($urandom_range(140, 60));
    end

    drain();
    if (n_mismatch == 0) begin
      $display("PASS boundary_flood_fill_capture");
    end else begin
      $display("FAIL boundary_flood_fill_capture");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bffc_pkg.sv
rtl/bffc_ram.sv
rtl/bffc_fill_ctrl.sv
rtl/boundary_flood_fill_capture.sv
tb/boundary_flood_fill_capture_tb.sv
